// File: hw/rtl/lfu_pkg.sv
`default_nettype none

package lfu_pkg;

  // Table geometry
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 32;
  localparam int STAMP_W = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } lfu_action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } lfu_state_e;

  // Request transaction
  typedef struct packed {
    lfu_action_e        action;
    logic [KEY_W-1:0]   key;
    logic signed [VAL_W-1:0] value;
  } lfu_req_t;

  // Response transaction
  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic [KEY_W-1:0]        evicted_key;
  } lfu_rsp_t;

  // One table entry as seen by the scan unit
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [CNT_W-1:0]   count;
    logic [STAMP_W-1:0] stamp;
  } lfu_entry_t;

  // Scan unit control
  typedef struct packed {
    logic clear;
    logic step;
    logic [IDX_W-1:0] idx;
  } lfu_scan_ctl_t;

  // Scan results: first key match, LFU/LRU victim, lowest free slot
  typedef struct packed {
    logic               hit_found;
    logic [IDX_W-1:0]   hit_idx;
    logic [VAL_W-1:0]   hit_value;
    logic [CNT_W-1:0]   hit_count;
    logic               vic_found;
    logic [IDX_W-1:0]   vic_idx;
    logic [KEY_W-1:0]   vic_key;
    logic [CNT_W-1:0]   vic_count;
    logic [STAMP_W-1:0] vic_stamp;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
  } lfu_scan_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/lfu_scan.sv
`default_nettype none

module lfu_scan
  import lfu_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lfu_scan_ctl_t    ctl_i,
  input  wire logic [KEY_W-1:0] key_i,
  input  wire lfu_entry_t       entry_i,
  output lfu_scan_res_t         res_o
);

  lfu_scan_res_t res_q, res_d;
  logic          key_match;
  logic          vic_better;

  // Per-entry compares against the running best
  assign key_match  = entry_i.valid && (entry_i.key == key_i);
  assign vic_better = entry_i.valid &&
                      (!res_q.vic_found ||
                       (entry_i.count < res_q.vic_count) ||
                       ((entry_i.count == res_q.vic_count) &&
                        (entry_i.stamp < res_q.vic_stamp)));

  always_comb begin
    res_d = res_q;
    if (ctl_i.clear) begin
      res_d.hit_found  = 1'b0;
      res_d.vic_found  = 1'b0;
      res_d.free_found = 1'b0;
    end else if (ctl_i.step) begin
      // keep the matching entry's value and count for the update cycle
      if (!res_q.hit_found && key_match) begin
        res_d.hit_found = 1'b1;
        res_d.hit_idx   = ctl_i.idx;
        res_d.hit_value = entry_i.value;
        res_d.hit_count = entry_i.count;
      end
      if (vic_better) begin
        res_d.vic_found = 1'b1;
        res_d.vic_idx   = ctl_i.idx;
        res_d.vic_key   = entry_i.key;
        res_d.vic_count = entry_i.count;
        res_d.vic_stamp = entry_i.stamp;
      end
      if (!res_q.free_found && !entry_i.valid) begin
        res_d.free_found = 1'b1;
        res_d.free_idx   = ctl_i.idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// File: hw/rtl/lfu_cache_table.sv
// LFU key-value cache, 16 entries, LRU tie break among equal use counts.
// The response is registered after a scan of all 16 entries, one entry per
// scan step through the shared scan unit, followed by an update state.
// Requests do not overlap: the request side stalls from accept until the
// response transaction.
// Reset: all entries invalid, use clock and occupancy zero, capacity 16.
`default_nettype none

module lfu_cache_table
  import lfu_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire lfu_req_t         in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output lfu_rsp_t              out_data_o
);

  lfu_state_e state_q, state_d;

  logic [CAP_W-1:0]   capacity_q;
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic [STAMP_W-1:0] clock_q;
  logic [ENTRIES-1:0] valid_q;
  logic [IDX_W-1:0]   scan_idx_q;
  lfu_req_t           req_q;
  lfu_rsp_t           rsp_q;
  lfu_entry_t         rd_q;

  // Entry storage, read at one address
  logic [KEY_W-1:0]   key_mem   [ENTRIES];
  logic [VAL_W-1:0]   value_mem [ENTRIES];
  logic [CNT_W-1:0]   count_mem [ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [ENTRIES];

  logic          in_accept, out_accept;
  logic          scan_last;
  lfu_scan_ctl_t scan_ctl;
  lfu_scan_res_t scan_res;
  logic [IDX_W-1:0] rd_addr;

  logic [OCC_W-1:0]   cap_eff;
  logic               is_put;
  logic               do_touch, do_evict, do_insert, slot_ok;
  logic [IDX_W-1:0]   slot_idx;
  logic [STAMP_W-1:0] clock_inc;
  logic [CNT_W-1:0]   count_inc;
  lfu_rsp_t           rsp_d;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_o && !out_stall_i;
  assign scan_last  = (scan_idx_q == IDX_W'(ENTRIES - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_accept)  state_d = ST_SCAN;
      ST_SCAN:   if (scan_last)  state_d = ST_UPDATE;
      ST_UPDATE:                 state_d = ST_RESP;
      ST_RESP:   if (out_accept) state_d = ST_IDLE;
      default:                   state_d = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall_o     = 1'b1;
    out_valid_o    = 1'b0;
    scan_ctl.clear = 1'b0;
    scan_ctl.step  = 1'b0;
    scan_ctl.idx   = scan_idx_q;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        scan_ctl.clear = 1'b1;
      end
      ST_SCAN:   scan_ctl.step = 1'b1;
      ST_UPDATE: ;
      ST_RESP:   out_valid_o = 1'b1;
      default:   ;
    endcase
  end

  // Registered read port: fetch the next entry while scanning, entry 0 otherwise,
  // so entry 0 is ready in the first scan cycle
  assign rd_addr = (state_q == ST_SCAN) ? scan_idx_q + IDX_W'(1) : '0;

  lfu_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .key_i   (req_q.key),
    .entry_i (rd_q),
    .res_o   (scan_res)
  );

  // Update decisions
  always_comb begin
    if (int'(capacity_q) > ENTRIES) begin
      cap_eff = OCC_W'(ENTRIES);
    end else begin
      cap_eff = OCC_W'(capacity_q);
    end
    is_put    = (req_q.action == ACT_PUT);
    clock_inc = clock_q + STAMP_W'(1);
    count_inc = (scan_res.hit_count == '1) ? scan_res.hit_count
                                            : scan_res.hit_count + CNT_W'(1);
    do_touch  = scan_res.hit_found;
    do_evict  = is_put && !scan_res.hit_found && (cap_eff != '0) &&
                (occ_q >= cap_eff) && scan_res.vic_found;
    if (do_evict && (!scan_res.free_found || (scan_res.vic_idx < scan_res.free_idx))) begin
      slot_idx = scan_res.vic_idx;
    end else begin
      slot_idx = scan_res.free_idx;
    end
    slot_ok   = scan_res.free_found || do_evict;
    do_insert = is_put && !scan_res.hit_found && (cap_eff != '0) && slot_ok;

    occ_d = occ_q;
    if (do_insert && !do_evict) begin
      occ_d = occ_q + OCC_W'(1);
    end else if (do_evict && !do_insert) begin
      occ_d = occ_q - OCC_W'(1);
    end

    rsp_d.hit         = scan_res.hit_found;
    rsp_d.evicted     = do_evict;
    rsp_d.evicted_key = do_evict ? scan_res.vic_key : '0;
    if (is_put) begin
      rsp_d.read_value = '0;
    end else if (scan_res.hit_found) begin
      rsp_d.read_value = scan_res.hit_value;
    end else begin
      rsp_d.read_value = '1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      capacity_q <= CAP_RESET;
      occ_q      <= '0;
      clock_q    <= '0;
      valid_q    <= '0;
      scan_idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        scan_idx_q <= '0;
      end else if (state_q == ST_SCAN) begin
        scan_idx_q <= scan_idx_q + IDX_W'(1);
      end
      if (state_q == ST_UPDATE) begin
        occ_q <= occ_d;
        if (do_touch || do_insert) begin
          clock_q <= clock_inc;
        end
        if (do_evict) begin
          valid_q[scan_res.vic_idx] <= 1'b0;
        end
        if (do_insert) begin
          valid_q[slot_idx] <= 1'b1;
        end
      end
    end
  end

  // Request latch, response register, entry storage and its read register
  always_ff @(posedge clk_i) begin
    rd_q.valid <= valid_q[rd_addr];
    rd_q.key   <= key_mem[rd_addr];
    rd_q.value <= value_mem[rd_addr];
    rd_q.count <= count_mem[rd_addr];
    rd_q.stamp <= stamp_mem[rd_addr];
    if (in_accept) begin
      req_q <= in_data_i;
    end
    if (state_q == ST_UPDATE) begin
      rsp_q <= rsp_d;
      if (do_touch) begin
        count_mem[scan_res.hit_idx] <= count_inc;
        stamp_mem[scan_res.hit_idx] <= clock_inc;
        if (is_put) begin
          value_mem[scan_res.hit_idx] <= req_q.value;
        end
      end
      if (do_insert) begin
        key_mem[slot_idx]   <= req_q.key;
        value_mem[slot_idx] <= req_q.value;
        count_mem[slot_idx] <= CNT_W'(1);
        stamp_mem[slot_idx] <= clock_inc;
      end
    end
  end

  assign out_data_o = rsp_q;

`ifndef SYNTH
  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(occ_q) == $countones(valid_q))
    else $error("occupancy differs from number of valid entries");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(occ_q) <= ENTRIES)
    else $error("occupancy above table size");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_SCAN) && (scan_idx_q == '0))
    else $error("accepted request did not start a scan");

  a_evict_only_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.evicted |-> !out_data_o.hit)
    else $error("eviction reported together with a hit");
`endif

endmodule

`default_nettype wire
